// ===== rtl/ucfh_pkg.sv =====
`timescale 1ns / 1ps
package ucfh_pkg;

   localparam logic [7:0] HDR_BYTE   = 8'hA4;
   localparam logic [7:0] CMD_STATUS = 8'h01;
   localparam logic [7:0] CMD_TARGET = 8'h11;
   localparam logic [7:0] REPLY_LEN  = 8'h01;
   localparam logic [7:0] STATUS_SUM = 8'hA6;
   localparam logic [7:0] TARGET_SUM = 8'(HDR_BYTE + CMD_TARGET + REPLY_LEN);

   // Header is four bytes: header byte, command, length, header sum.
   localparam int HDR_BYTES  = 4;
   localparam int POS_BYTES  = 4;

   localparam int REPLY_BEATS = 6;
   localparam int BEAT_W      = $clog2(REPLY_BEATS);
   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(REPLY_BEATS - 1);

   localparam int QDEPTH = 4;

   typedef struct packed {
      logic        target;
      logic [31:0] position;
   } reply_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== rtl/ucfh_req_if.sv =====
`timescale 1ns / 1ps
interface ucfh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== rtl/ucfh_rsp_if.sv =====
`timescale 1ns / 1ps
interface ucfh_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         reply_byte;
   logic               reply_last;
   logic               position_valid;
   logic signed [31:0] new_position;

   modport source (output valid, output reply_byte, output reply_last,
                   output position_valid, output new_position, input ready);
   modport sink (input valid, input reply_byte, input reply_last,
                 input position_valid, input new_position, output ready);
endinterface

// ===== rtl/ucfh_front.sv =====
`timescale 1ns / 1ps
module ucfh_front #(
   parameter int MAX_FRAME_BYTES = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   ucfh_req_if.sink                 req_if,
   input  ucfh_pkg::qstat_type      qstat,
   output logic                     push,
   output ucfh_pkg::reply_desc_type push_desc
);

   logic [4:0]  byte_count_ff, byte_count_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  sum_ff, sum_in;
   logic        header_good_ff, header_good_in;
   logic        data_good_ff, data_good_in;
   logic [31:0] position_ff, position_in;

   logic        accept;
   logic [8:0]  data_end;
   logic [8:0]  idx_wide;
   logic        reply_ok;
   logic [7:0]  b;

   assign req_if.ready = !qstat.full;
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.rx_byte;
   assign data_end     = 9'(ucfh_pkg::HDR_BYTES) + {1'b0, length_ff};
   assign idx_wide     = {4'b0000, byte_count_ff};

   always_comb begin
      byte_count_in  = byte_count_ff;
      command_in     = command_ff;
      length_in      = length_ff;
      sum_in         = sum_ff;
      header_good_in = header_good_ff;
      data_good_in   = data_good_ff;
      position_in    = position_ff;
      // Bytes past the buffer length leave the frame state alone.
      if (byte_count_ff < 5'(MAX_FRAME_BYTES)) begin
         priority if (byte_count_ff == 5'd0) begin
            header_good_in = (b == ucfh_pkg::HDR_BYTE);
            data_good_in   = 1'b0;
            position_in    = '0;
            sum_in         = b;
         end else if (byte_count_ff < 5'd3) begin
            if (byte_count_ff == 5'd1) begin
               command_in = b;
            end else begin
               length_in = b;
            end
            sum_in = sum_ff + b;
         end else if (byte_count_ff == 5'd3) begin
            header_good_in = header_good_ff && (sum_ff == b);
            sum_in         = '0;
         end else if (idx_wide < data_end) begin
            sum_in = sum_ff + b;
            if (byte_count_ff < 5'(ucfh_pkg::HDR_BYTES + ucfh_pkg::POS_BYTES)) begin
               position_in[{byte_count_ff[1:0], 3'b000} +: 8] = b;
            end
         end else if (idx_wide == data_end) begin
            data_good_in = (sum_ff == b);
         end else begin
            sum_in = sum_ff;
         end
         byte_count_in = byte_count_ff + 5'd1;
      end
   end

   assign reply_ok = (byte_count_in >= 5'(ucfh_pkg::HDR_BYTES)) && header_good_in &&
                     ((command_in == ucfh_pkg::CMD_STATUS) ||
                      ((command_in == ucfh_pkg::CMD_TARGET) &&
                       (length_in >= 8'(ucfh_pkg::POS_BYTES)) && data_good_in));

   assign push               = accept && req_if.frame_end && reply_ok;
   assign push_desc.target   = (command_in == ucfh_pkg::CMD_TARGET);
   assign push_desc.position = position_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_if.frame_end)) begin
         byte_count_ff  <= '0;
         command_ff     <= '0;
         length_ff      <= '0;
         sum_ff         <= '0;
         header_good_ff <= 1'b0;
         data_good_ff   <= 1'b0;
         position_ff    <= '0;
      end else if (accept) begin
         byte_count_ff  <= byte_count_in;
         command_ff     <= command_in;
         length_ff      <= length_in;
         sum_ff         <= sum_in;
         header_good_ff <= header_good_in;
         data_good_ff   <= data_good_in;
         position_ff    <= position_in;
      end
   end

endmodule

// ===== rtl/ucfh_queue.sv =====
`timescale 1ns / 1ps
module ucfh_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ucfh_pkg::reply_desc_type push_desc,
   input  logic                     pop,
   output ucfh_pkg::reply_desc_type head_desc,
   output ucfh_pkg::qstat_type      qstat
);

   localparam int PTR_W = $clog2(ucfh_pkg::QDEPTH);
   localparam int CNT_W = $clog2(ucfh_pkg::QDEPTH + 1);

   ucfh_pkg::reply_desc_type entry_ff [ucfh_pkg::QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign qstat.full  = (count_ff == CNT_W'(ucfh_pkg::QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_desc   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(ucfh_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(ucfh_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== rtl/ucfh_back.sv =====
`timescale 1ns / 1ps
module ucfh_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ucfh_pkg::reply_desc_type head_desc,
   input  ucfh_pkg::qstat_type      qstat,
   output logic                     pop,
   ucfh_rsp_if.source               rsp_if
);

   logic [ucfh_pkg::BEAT_W-1:0] beat_ff, beat_in;
   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic                        pos_valid_ff, pos_valid_in;
   logic [31:0]                 position_ff, position_in;
   logic                        load, emit;

   // The output register takes a new beat whenever it is empty or drained.
   assign load = !valid_ff || rsp_if.ready;
   assign emit = load && !qstat.empty;
   // The descriptor stays at the head of the queue until its last beat is loaded into the output register.
   assign pop  = emit && (beat_ff == ucfh_pkg::LAST_BEAT);

   always_comb begin
      unique case (beat_ff)
         3'd0:    byte_in = ucfh_pkg::HDR_BYTE;
         3'd1:    byte_in = head_desc.target ? ucfh_pkg::CMD_TARGET : ucfh_pkg::CMD_STATUS;
         3'd2:    byte_in = ucfh_pkg::REPLY_LEN;
         3'd3:    byte_in = head_desc.target ? ucfh_pkg::TARGET_SUM : ucfh_pkg::STATUS_SUM;
         default: byte_in = 8'h00;
      endcase
      last_in      = (beat_ff == ucfh_pkg::LAST_BEAT);
      pos_valid_in = (beat_ff == '0) && head_desc.target;
      position_in  = pos_valid_in ? head_desc.position : '0;
      valid_in     = load ? emit : valid_ff;
      beat_in      = beat_ff;
      if (emit) begin
         beat_in = last_in ? '0 : beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff      <= byte_in;
         last_ff      <= last_in;
         pos_valid_ff <= pos_valid_in;
         position_ff  <= position_in;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.reply_byte     = byte_ff;
   assign rsp_if.reply_last     = last_ff;
   assign rsp_if.position_valid = pos_valid_ff;
   assign rsp_if.new_position   = position_ff;

endmodule

// ===== rtl/uart_command_frame_handler_core.sv =====
`timescale 1ns / 1ps
// Serial command frame handler.
// The req channel carries one received byte per beat, with frame_end set on
// the last byte before line idle. The rsp channel carries the six-byte reply
// of a good frame, one byte per beat, reply_last on the sixth; the first beat
// of a target reply also carries position_valid and the new signed position.
// Bad, short or unknown frames produce no beats at all.
// Throughput: one request beat per cycle while the reply queue is not full.
// Each byte updates a running sum and a few compares in the frame parser.
// A reply leaves the output register one beat per cycle while rsp is ready.
// When the reply queue was empty, the decoded frame of the closing byte is
// first written into the queue, and the queue head is then loaded into the
// output register as the first reply beat.
// Decoded frames wait in a four-entry reply queue; the parser keeps taking
// bytes while the output is stalled and drops req ready only while that
// queue is full. Reset is synchronous and clears the parser, the queue and
// the output register; no beats are valid until a frame is received.
module uart_command_frame_handler_core #(
   parameter int MAX_FRAME_BYTES = 20
) (
   input  logic       clock,
   input  logic       reset,
   ucfh_req_if.sink   req_if,
   ucfh_rsp_if.source rsp_if
);

   ucfh_pkg::reply_desc_type push_desc, head_desc;
   ucfh_pkg::qstat_type      qstat;
   logic                     push, pop;

   ucfh_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .qstat     (qstat),
      .push      (push),
      .push_desc (push_desc)
   );

   ucfh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .qstat     (qstat)
   );

   ucfh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_desc (head_desc),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

   // The parser must never close a good frame into a full reply queue.
   assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !req_if.ready)
      else $error("request taken while reply queue full");

   // A position is only announced on the header beat of a reply.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.position_valid) |->
         (rsp_if.reply_byte == ucfh_pkg::HDR_BYTE) && !rsp_if.reply_last)
      else $error("position on a beat other than the first");

   // Beats of one reply follow each other without a gap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && !rsp_if.reply_last) |=> rsp_if.valid)
      else $error("gap inside a reply");

   // A descriptor is only popped from a non-empty queue.
   assert property (@(posedge clock) disable iff (reset)
      (pop) |-> !qstat.empty)
      else $error("reply ended with an empty queue");

endmodule
